// ===== rtl/php_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// php_pkg: shared types and constants of the packet header parser
// Frame class codes, EtherType values and the word carried from the
// front (byte absorber) to the back (result builder).
// ----------------------------------------------------------------------------
package php_pkg;

	localparam int MaxFrameBytes = 16383;
	localparam logic [15:0] EthHdrBytes = 16'd14;
	localparam logic [15:0] KindIpv4 = 16'h0800;
	localparam logic [15:0] KindArp = 16'h0806;
	localparam logic [15:0] FlagFieldMask = 16'h0FFF;

	typedef enum logic [3:0] {
		CLS_SHORT = 4'd0,
		CLS_OTHER = 4'd1,
		CLS_ARP_REQ = 4'd2,
		CLS_ARP_REPLY = 4'd3,
		CLS_ARP_OTHER = 4'd4,
		CLS_ICMP = 4'd5,
		CLS_TCP = 4'd6,
		CLS_UDP = 4'd7,
		CLS_IP_OTHER = 4'd8
	} pkt_class_t;

	localparam logic [7:0] ProtoIcmp = 8'd1;
	localparam logic [7:0] ProtoTcp = 8'd6;
	localparam logic [7:0] ProtoUdp = 8'd17;

	// frame summary handed from the front to the back
	typedef struct packed {
		logic [15:0] pos;
		logic [15:0] ether_kind;
		logic [5:0]  hdr;
		logic [15:0] total_len;
		logic [7:0]  protocol;
		logic [15:0] ip_sum;
		logic [15:0] tcp_sum;
		logic [15:0] arp_op;
		logic [63:0] f0;
		logic [63:0] f1;
		logic [7:0]  ttl;
	} frame_sum_t;

	// one's-complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

// ===== rtl/php_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// php_front: byte absorber
// Tracks position, captures header fields and keeps both running sums;
// pushes one frame summary when the last byte arrives.
// ----------------------------------------------------------------------------
module php_front import php_pkg::*; #(
	parameter int MAX_FRAME_BYTES = MaxFrameBytes
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       push,
	output frame_sum_t push_word
);

	logic [15:0] pos_q, kind_q, tlen_q, ipsum_q, tcpsum_q, arp_q;
	logic [5:0]  hdr_q;
	logic [7:0]  proto_q, ttl_q;
	logic [63:0] f0_q, f1_q;

	frame_sum_t nx;
	logic        absorb;
	logic [15:0] w, l4, k, seg;

	// compute the updated state for this byte
	always_comb begin
		nx = '{pos: pos_q, ether_kind: kind_q, hdr: hdr_q, total_len: tlen_q,
			protocol: proto_q, ip_sum: ipsum_q, tcp_sum: tcpsum_q, arp_op: arp_q,
			f0: f0_q, f1: f1_q, ttl: ttl_q};
		absorb = {16'd0, pos_q} < 32'(MAX_FRAME_BYTES);
		w = pos_q[0] ? {8'd0, data_byte} : {data_byte, 8'd0};
		if (absorb) begin
			nx.pos = pos_q + 16'd1;
			if (pos_q == 16'd12) nx.ether_kind[15:8] = data_byte;
			if (pos_q == 16'd13) nx.ether_kind[7:0] = data_byte;
			if (pos_q == 16'd14) nx.hdr = {data_byte[3:0], 2'b00};
			if (pos_q == 16'd16) nx.total_len[15:8] = data_byte;
			if (pos_q == 16'd17) nx.total_len[7:0] = data_byte;
			if (pos_q == 16'd20) nx.arp_op[15:8] = data_byte;
			if (pos_q == 16'd21) nx.arp_op[7:0] = data_byte;
			if (pos_q == 16'd22) nx.ttl = data_byte;
			if (pos_q == 16'd23) nx.protocol = data_byte;
		end
		// take offsets from the lengths as updated by this byte
		l4 = EthHdrBytes + {10'd0, nx.hdr};
		k = pos_q - l4;
		seg = (nx.total_len > {10'd0, nx.hdr}) ? nx.total_len - {10'd0, nx.hdr} : 16'd0;
		if (absorb) begin
			if (pos_q >= EthHdrBytes && pos_q < l4)
				nx.ip_sum = oc_add(ipsum_q, w);
			// address bytes and segment bytes never overlap with each other once hdr>=20;
			// otherwise chain both adds as the model does
			if (pos_q >= 16'd26 && pos_q < 16'd34)
				nx.tcp_sum = oc_add(tcpsum_q, w);
			if (pos_q >= l4) begin
				if (k < seg) nx.tcp_sum = oc_add(nx.tcp_sum, w);
				if (k < 16'd8) nx.f0[(7 - k[2:0]) * 8 +: 8] = data_byte;
				else if (k < 16'd16) nx.f1[(7 - k[2:0]) * 8 +: 8] = data_byte;
			end
		end
	end

	assign push = in_fire && last_byte;
	assign push_word = nx;

	// advance state; clear it when the frame closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; kind_q <= '0; hdr_q <= '0; tlen_q <= '0; proto_q <= '0;
			ipsum_q <= '0; tcpsum_q <= '0; arp_q <= '0; f0_q <= '0; f1_q <= '0;
			ttl_q <= '0;
		end else if (in_fire) begin
			if (last_byte) begin
				pos_q <= '0; kind_q <= '0; hdr_q <= '0; tlen_q <= '0; proto_q <= '0;
				ipsum_q <= '0; tcpsum_q <= '0; arp_q <= '0; f0_q <= '0; f1_q <= '0;
				ttl_q <= '0;
			end else begin
				pos_q <= nx.pos; kind_q <= nx.ether_kind; hdr_q <= nx.hdr;
				tlen_q <= nx.total_len; proto_q <= nx.protocol; ipsum_q <= nx.ip_sum;
				tcpsum_q <= nx.tcp_sum; arp_q <= nx.arp_op; f0_q <= nx.f0;
				f1_q <= nx.f1; ttl_q <= nx.ttl;
			end
		end
	end

endmodule

// ===== rtl/php_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// php_queue: two-entry queue between front and back
// Holds frame summaries so the front keeps taking bytes while the back stalls.
// ----------------------------------------------------------------------------
module php_queue import php_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_sum_t push_word,
	output logic       full,
	output logic       pop_valid,
	input  logic       pop,
	output frame_sum_t pop_word
);

	frame_sum_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign pop_valid = cnt_q != 2'd0;
	assign pop_word = mem_q[rp_q];

	// store the word
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_word;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== rtl/php_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// php_back: result builder
// Classifies a frame summary, finishes both checksums and holds the result
// word in an output register.
// ----------------------------------------------------------------------------
module php_back import php_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  frame_sum_t  fs,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  packet_class,
	output logic        ip_checksum_ok,
	output logic        tcp_checksum_ok,
	output logic [7:0]  time_to_live,
	output logic [15:0] source_port,
	output logic [15:0] destination_port,
	output logic [31:0] sequence_number,
	output logic [31:0] acknowledgment_number,
	output logic [3:0]  tcp_flags,
	output logic [15:0] receive_window,
	output logic [7:0]  icmp_type,
	output logic [15:0] transport_length
);

	logic        vld_q;
	pkt_class_t  cls;
	logic [15:0] seg, s, fl, end_ip;
	logic [16:0] end_tcp;
	logic        ipok, tcpok;

	// classify and verify
	always_comb begin
		seg = (fs.total_len > {10'd0, fs.hdr}) ? fs.total_len - {10'd0, fs.hdr} : 16'd0;
		if (fs.pos < EthHdrBytes) cls = CLS_SHORT;
		else if (fs.ether_kind == KindArp)
			cls = (fs.arp_op == 16'd1) ? CLS_ARP_REQ :
				(fs.arp_op == 16'd2) ? CLS_ARP_REPLY : CLS_ARP_OTHER;
		else if (fs.ether_kind == KindIpv4)
			cls = (fs.protocol == ProtoIcmp) ? CLS_ICMP : (fs.protocol == ProtoTcp) ? CLS_TCP :
				(fs.protocol == ProtoUdp) ? CLS_UDP : CLS_IP_OTHER;
		else cls = CLS_OTHER;
		end_ip = EthHdrBytes + {10'd0, fs.hdr};
		end_tcp = {1'b0, end_ip} + {1'b0, seg};
		s = oc_add(oc_add(fs.tcp_sum, 16'd6), seg);
		fl = fs.f1[31:16] & FlagFieldMask;
		ipok = fs.pos >= end_ip && fs.ip_sum == 16'hFFFF;
		tcpok = fs.hdr >= 6'd20 && {1'b0, fs.pos} >= end_tcp && s == 16'hFFFF;
	end

	assign pop = in_valid && (!vld_q || !out_stall);
	assign out_valid = vld_q;

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (!vld_q || !out_stall) vld_q <= in_valid;
	end

	// load the result word
	always_ff @(posedge clk) begin
		if (pop) begin
			packet_class <= cls;
			ip_checksum_ok <= (cls >= CLS_ICMP) && ipok;
			time_to_live <= (cls >= CLS_ICMP) ? fs.ttl : 8'd0;
			transport_length <= (cls >= CLS_ICMP) ? seg : 16'd0;
			source_port <= (cls == CLS_TCP || cls == CLS_UDP) ? fs.f0[63:48] : 16'd0;
			destination_port <= (cls == CLS_TCP || cls == CLS_UDP) ? fs.f0[47:32] : 16'd0;
			tcp_checksum_ok <= (cls == CLS_TCP) && tcpok;
			sequence_number <= (cls == CLS_TCP) ? fs.f0[31:0] : 32'd0;
			acknowledgment_number <= (cls == CLS_TCP) ? fs.f1[63:32] : 32'd0;
			tcp_flags <= (cls == CLS_TCP) ? {fl[4], fl[2], fl[1], fl[0]} : 4'd0;
			receive_window <= (cls == CLS_TCP) ? fs.f1[15:0] : 16'd0;
			icmp_type <= (cls == CLS_ICMP) ? fs.f0[63:56] : 8'd0;
		end
	end

endmodule

// ===== rtl/packet_header_parser.sv =====
`timescale 1ns / 1ps
// The queue takes a frame's summary with its last byte; the back registers the result.
// Throughput: one byte per cycle while the queue has room for a closing byte.
// The two-entry summary queue lets bytes keep flowing while a result is stalled.
// Reset: arst_n clears all frame state, the queue and the output valid at once.
// ----------------------------------------------------------------------------
// packet_header_parser: Ethernet/IPv4/TCP/UDP header parser
// Front absorbs bytes, a queue carries frame summaries, the back builds results.
// ----------------------------------------------------------------------------
module packet_header_parser import php_pkg::*; #(
	parameter int MAX_FRAME_BYTES = MaxFrameBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  packet_class,
	output logic        ip_checksum_ok,
	output logic        tcp_checksum_ok,
	output logic [7:0]  time_to_live,
	output logic [15:0] source_port,
	output logic [15:0] destination_port,
	output logic [31:0] sequence_number,
	output logic [31:0] acknowledgment_number,
	output logic [3:0]  tcp_flags,
	output logic [15:0] receive_window,
	output logic [7:0]  icmp_type,
	output logic [15:0] transport_length
);

	logic       full, push, qv, pop;
	frame_sum_t pw, qw;

	// stall only when a closing byte would find the queue full
	assign in_stall = full && last_byte;

	php_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
		.clk, .arst_n, .in_fire(in_valid && !in_stall), .data_byte, .last_byte,
		.push, .push_word(pw)
	);

	php_queue u_queue (
		.clk, .arst_n, .push, .push_word(pw), .full, .pop_valid(qv), .pop, .pop_word(qw)
	);

	php_back u_back (
		.clk, .arst_n, .in_valid(qv), .fs(qw), .pop, .out_valid, .out_stall,
		.packet_class, .ip_checksum_ok, .tcp_checksum_ok, .time_to_live, .source_port,
		.destination_port, .sequence_number, .acknowledgment_number, .tcp_flags,
		.receive_window, .icmp_type, .transport_length
	);

endmodule

// ===== rtl/php_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// php_checker: port-level checks for the packet header parser
// Watches the ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module php_checker import php_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] packet_class,
	input logic       ip_checksum_ok,
	input logic       tcp_checksum_ok,
	input logic [7:0] icmp_type
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(packet_class))
		else $error("stalled result changed");

	// class codes stay in range
	a_cls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> packet_class <= CLS_IP_OTHER)
		else $error("bad class");

	// tcp verdict only for tcp
	a_tcp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tcp_checksum_ok |-> packet_class == CLS_TCP)
		else $error("tcp verdict on non-tcp");

	// ip verdict only for ipv4 classes
	a_ip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ip_checksum_ok |-> packet_class >= CLS_ICMP)
		else $error("ip verdict on non-ip");

	// icmp type only for icmp
	a_icmp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packet_class != CLS_ICMP |-> icmp_type == 8'd0)
		else $error("icmp type leak");

endmodule

bind packet_header_parser php_checker u_php_checker (
	.clk, .arst_n, .out_valid, .out_stall, .packet_class, .ip_checksum_ok,
	.tcp_checksum_ok, .icmp_type
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the packet header parser
// Builds whole frames (ARP, IPv4 ICMP/TCP/UDP, short, truncated, broken)
// and feeds them one word per handshake. A frame checker predicts
// each frame's result and compares it with every result the parser hands out.
// ----------------------------------------------------------------------------
module tb_top;
	import php_pkg::*;

	typedef struct {
		bit [3:0]    cls;
		bit          ip_ok;
		bit          tcp_ok;
		bit [7:0]    ttl;
		bit [15:0]   sport;
		bit [15:0]   dport;
		bit [31:0]   seq;
		bit [31:0]   ack;
		bit [3:0]    flags;
		bit [15:0]   window;
		bit [7:0]    icmp;
		bit [15:0]   seg_len;
	} frame_result_t;

	// frame checker: tracks the parser state and holds the expected results
	class frame_checker;
		bit [15:0] pos, kind, tot, arp_op, ip_sum, tcp_sum;
		bit [5:0]  hdr;
		bit [7:0]  proto, ttl;
		bit [63:0] f0, f1;
		frame_result_t expected_results[$];
		int errors;

		function bit [15:0] ones_add(bit [15:0] a, bit [15:0] b);
			bit [16:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[15:0] + {15'd0, s[16]};
		endfunction

		function int seg_bytes();
			return (tot > hdr) ? int'(tot) - int'(hdr) : 0;
		endfunction

		function void clear();
			pos = 0; kind = 0; tot = 0; arp_op = 0; ip_sum = 0; tcp_sum = 0;
			hdr = 0; proto = 0; ttl = 0; f0 = 0; f1 = 0;
		endfunction

		// absorb one word at its frame position
		function void absorb(int p, bit [7:0] b);
			bit [15:0] w;
			int l4, k;
			w = p[0] ? {8'h00, b} : {b, 8'h00};
			case (p)
				12: kind[15:8] = b;
				13: kind[7:0] = b;
				14: hdr = {b[3:0], 2'b00};
				16: tot[15:8] = b;
				17: tot[7:0] = b;
				20: arp_op[15:8] = b;
				21: arp_op[7:0] = b;
				22: ttl = b;
				23: proto = b;
				default: ;
			endcase
			if (p >= 14 && p < 14 + int'(hdr))
				ip_sum = ones_add(ip_sum, w);
			if (p >= 26 && p < 34)
				tcp_sum = ones_add(tcp_sum, w);
			l4 = 14 + int'(hdr);
			if (p >= l4) begin
				k = p - l4;
				if (k < seg_bytes())
					tcp_sum = ones_add(tcp_sum, w);
				if (k < 8)
					f0 |= 64'(b) << (56 - 8 * k);
				else if (k < 16)
					f1 |= 64'(b) << (56 - 8 * (k - 8));
			end
		endfunction

		// note one accepted word; the last word of a frame yields a result
		function void note_word(bit [7:0] b, bit last);
			frame_result_t r;
			int seg;
			bit [15:0] s, fl;
			if (int'(pos) < MaxFrameBytes) begin
				absorb(int'(pos), b);
				pos++;
			end
			if (!last)
				return;
			r = '{default: 0};
			seg = seg_bytes();
			if (pos < EthHdrBytes)
				r.cls = CLS_SHORT;
			else if (kind == KindArp)
				r.cls = (arp_op == 16'd1) ? CLS_ARP_REQ :
					(arp_op == 16'd2) ? CLS_ARP_REPLY : CLS_ARP_OTHER;
			else if (kind == KindIpv4)
				r.cls = (proto == ProtoIcmp) ? CLS_ICMP : (proto == ProtoTcp) ? CLS_TCP :
					(proto == ProtoUdp) ? CLS_UDP : CLS_IP_OTHER;
			else
				r.cls = CLS_OTHER;
			if (r.cls >= CLS_ICMP) begin
				r.ip_ok = (int'(pos) >= 14 + int'(hdr)) && ip_sum == 16'hFFFF;
				r.ttl = ttl;
				r.seg_len = seg[15:0];
			end
			if (r.cls == CLS_TCP || r.cls == CLS_UDP) begin
				r.sport = f0[63:48];
				r.dport = f0[47:32];
			end
			if (r.cls == CLS_TCP) begin
				s = ones_add(ones_add(tcp_sum, 16'd6), seg[15:0]);
				fl = f1[31:16] & FlagFieldMask;
				r.tcp_ok = hdr >= 20 && int'(pos) >= 14 + int'(hdr) + seg && s == 16'hFFFF;
				r.seq = f0[31:0];
				r.ack = f1[63:32];
				r.flags = {fl[4], fl[2], fl[1], fl[0]};
				r.window = f1[15:0];
			end
			if (r.cls == CLS_ICMP)
				r.icmp = f0[63:56];
			expected_results.push_back(r);
			clear();
		endfunction

		task report(string field, longint got, longint want);
			errors++;
			$display("%0t mismatch %s: got %0h want %0h", $realtime, field, got, want);
		endtask

		task check_result(frame_result_t a);
			frame_result_t e;
			if (expected_results.size() == 0) begin
				report("unexpected result", a.cls, 0);
				return;
			end
			e = expected_results.pop_front();
			if (a.cls !== e.cls) report("packet_class", a.cls, e.cls);
			if (a.ip_ok !== e.ip_ok) report("ip_checksum_ok", a.ip_ok, e.ip_ok);
			if (a.tcp_ok !== e.tcp_ok) report("tcp_checksum_ok", a.tcp_ok, e.tcp_ok);
			if (a.ttl !== e.ttl) report("time_to_live", a.ttl, e.ttl);
			if (a.sport !== e.sport) report("source_port", a.sport, e.sport);
			if (a.dport !== e.dport) report("destination_port", a.dport, e.dport);
			if (a.seq !== e.seq) report("sequence_number", a.seq, e.seq);
			if (a.ack !== e.ack) report("acknowledgment_number", a.ack, e.ack);
			if (a.flags !== e.flags) report("tcp_flags", a.flags, e.flags);
			if (a.window !== e.window) report("receive_window", a.window, e.window);
			if (a.icmp !== e.icmp) report("icmp_type", a.icmp, e.icmp);
			if (a.seg_len !== e.seg_len) report("transport_length", a.seg_len, e.seg_len);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  packet_class;
	logic        ip_checksum_ok, tcp_checksum_ok;
	logic [7:0]  time_to_live, icmp_type;
	logic [15:0] source_port, destination_port, receive_window, transport_length;
	logic [31:0] sequence_number, acknowledgment_number;
	logic [3:0]  tcp_flags;

	frame_checker chk = new;
	bit [7:0] frame_q[$];
	int sender_idle_pct = 22;
	int recv_stall_pct = 49;
	int idle_cycles = 0;
	int words_sent = 0;

	packet_header_parser dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stall the result side at random
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// check each result word taken at the coming edge
	always @(negedge clk) begin
		frame_result_t a;
		if (arst_n && out_valid && !out_stall) begin
			a.cls = packet_class;
			a.ip_ok = ip_checksum_ok;
			a.tcp_ok = tcp_checksum_ok;
			a.ttl = time_to_live;
			a.sport = source_port;
			a.dport = destination_port;
			a.seq = sequence_number;
			a.ack = acknowledgment_number;
			a.flags = tcp_flags;
			a.window = receive_window;
			a.icmp = icmp_type;
			a.seg_len = transport_length;
			chk.check_result(a);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 4000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_word(bit [7:0] b, bit last);
		bit taken;
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		chk.note_word(b, last);
		words_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			send_word(frame_q[i], i == frame_q.size() - 1);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		while (chk.expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic push_random(int n);
		repeat (n) frame_q.push_back(8'($urandom));
	endtask

	task automatic make_eth(bit [15:0] kind);
		frame_q.delete();
		push_random(12);
		frame_q.push_back(kind[15:8]);
		frame_q.push_back(kind[7:0]);
	endtask

	function automatic bit [15:0] span_sum(bit [15:0] acc, int a, int b);
		for (int p = a; p < b; p++)
			acc = chk.ones_add(acc, p[0] ? {8'h00, frame_q[p]} : {frame_q[p], 8'h00});
		return acc;
	endfunction

	task automatic make_arp(bit [15:0] op);
		make_eth(KindArp);
		push_random(28);
		frame_q[20] = op[15:8];
		frame_q[21] = op[7:0];
	endtask

	// build an IPv4 frame; random total length when wild_len, corrupt when !good
	task automatic make_ip(int ihl, bit [7:0] proto, int paylen, bit good, bit wild_len);
		int hdr, l4, seg, p;
		bit [15:0] tot, s;
		hdr = ihl * 4;
		make_eth(KindIpv4);
		frame_q.push_back({4'h4, 4'(ihl)});
		push_random(9);
		frame_q[23] = proto;
		frame_q.push_back(8'h00);
		frame_q.push_back(8'h00);
		push_random(8 + ((hdr > 20) ? hdr - 20 : 0));
		l4 = (ihl >= 5) ? 14 + hdr : frame_q.size();
		case (proto)
			ProtoTcp: begin
				push_random(20);
				frame_q[l4 + 16] = 8'h00;
				frame_q[l4 + 17] = 8'h00;
			end
			ProtoUdp: push_random(8);
			ProtoIcmp: begin
				push_random(4);
				frame_q[l4] = $urandom_range(1) ? 8'd8 : 8'd0;
			end
			default: ;
		endcase
		push_random(paylen);
		seg = frame_q.size() - l4;
		tot = wild_len ? 16'($urandom) : 16'(hdr + seg);
		frame_q[16] = tot[15:8];
		frame_q[17] = tot[7:0];
		if (ihl >= 5) begin
			if (proto == ProtoTcp) begin
				s = span_sum(16'h0000, 26, 34);
				s = span_sum(s, l4, l4 + seg);
				s = chk.ones_add(chk.ones_add(s, 16'd6), 16'(seg));
				frame_q[l4 + 16] = ~s[15:8];
				frame_q[l4 + 17] = ~s[7:0];
			end
			s = span_sum(16'h0000, 14, 14 + hdr);
			frame_q[24] = ~s[15:8];
			frame_q[25] = ~s[7:0];
		end
		if (!good) begin
			p = $urandom_range(14, frame_q.size() - 1);
			frame_q[p] ^= 8'(1 << $urandom_range(7));
		end
	endtask

	task automatic random_frame();
		int pick, ihl;
		bit [7:0] proto;
		pick = $urandom_range(99);
		ihl = ($urandom_range(9) == 0) ? $urandom_range(15) : 5 + $urandom_range(1) * $urandom_range(10);
		case ($urandom_range(3))
			0: proto = ProtoTcp;
			1: proto = ProtoUdp;
			2: proto = ProtoIcmp;
			default: proto = 8'($urandom);
		endcase
		if (pick < 60)
			make_ip(ihl, proto, $urandom_range(12), 1, 0);
		else if (pick < 70) begin
			make_ip(ihl, proto, $urandom_range(12), $urandom_range(1), 1);
		end else if (pick < 78) begin
			make_ip(ihl, proto, $urandom_range(12), 0, 0);
		end else if (pick < 84) begin
			make_arp(($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2)));
		end else if (pick < 89) begin
			make_eth(16'($urandom));
			push_random($urandom_range(40));
		end else begin
			frame_q.delete();
			push_random($urandom_range(1, 13));
		end
		// chop the tail now and then
		if ($urandom_range(7) == 0 && frame_q.size() > 1)
			repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
	endtask

	initial begin
		int phase;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames
		frame_q = '{8'hFF};
		send_frame();
		frame_q.delete();
		push_random(13);
		send_frame();
		make_eth(16'h1234);
		send_frame();
		make_arp(16'd1);
		send_frame();
		make_arp(16'd2);
		send_frame();
		make_arp(16'hFFFF);
		send_frame();
		make_ip(5, ProtoIcmp, 3, 1, 0);
		send_frame();
		make_ip(5, ProtoTcp, 5, 1, 0);
		send_frame();
		make_ip(15, ProtoTcp, 0, 1, 0);
		send_frame();
		make_ip(5, ProtoUdp, 2, 1, 0);
		send_frame();
		make_ip(5, 8'hFF, 4, 1, 0);
		send_frame();
		make_ip(0, ProtoTcp, 4, 1, 0);
		send_frame();
		make_ip(3, ProtoTcp, 4, 1, 0);
		send_frame();
		make_ip(5, ProtoTcp, 6, 1, 0);
		frame_q[16] = 8'h00;
		frame_q[17] = 8'h05;
		send_frame();
		make_ip(5, ProtoTcp, 10, 1, 0);
		repeat (7) void'(frame_q.pop_back());
		send_frame();
		make_ip(5, ProtoTcp, 0, 1, 0);
		repeat (30) void'(frame_q.pop_back());
		send_frame();
		frame_q.delete();
		repeat (60) frame_q.push_back(8'hFF);
		send_frame();
		frame_q.delete();
		repeat (60) frame_q.push_back(8'h00);
		send_frame();

		// random frames in three idle phases
		words_sent = 0;
		phase = 0;
		while (words_sent < 500) begin
			if (phase == 0 && words_sent >= 170) begin
				wait_results();
				phase = 1;
				sender_idle_pct = 49;
				recv_stall_pct = 22;
			end else if (phase == 1 && words_sent >= 340) begin
				wait_results();
				phase = 2;
				sender_idle_pct = 0;
				recv_stall_pct = 0;
			end
			random_frame();
			send_frame();
		end

		wait_results();
		repeat (10) @(posedge clk);
		if (chk.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/php_pkg.sv
rtl/php_front.sv
rtl/php_queue.sv
rtl/php_back.sv
rtl/packet_header_parser.sv
rtl/php_checker.sv
verif/tb_top.sv
